FILE: sv/clfd_pkg.sv
`timescale 1ns / 1ps

package clfd_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] body_byte;
        logic       frame_last;
        logic [2:0] error_code;
    } out_item_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [2:0] ERR_HDR_BIG  = 3'd0;
    localparam logic [2:0] ERR_DELIM    = 3'd1;
    localparam logic [2:0] ERR_LINE     = 3'd2;
    localparam logic [2:0] ERR_DUP      = 3'd3;
    localparam logic [2:0] ERR_INVALID  = 3'd4;
    localparam logic [2:0] ERR_BODY_BIG = 3'd5;
    localparam logic [2:0] ERR_MISSING  = 3'd6;
    localparam logic [2:0] ERR_PARTIAL  = 3'd7;

    localparam logic [2:0] PH_NAME_LEAD   = 3'd0;
    localparam logic [2:0] PH_NAME        = 3'd1;
    localparam logic [2:0] PH_NAME_TRAIL  = 3'd2;
    localparam logic [2:0] PH_VAL_LEAD    = 3'd3;
    localparam logic [2:0] PH_VAL_DIGITS  = 3'd4;
    localparam logic [2:0] PH_VAL_TRAIL   = 3'd5;
    localparam logic [2:0] PH_SKIP        = 3'd6;
    localparam logic [2:0] PH_EMPTY_FIRST = 3'd7;

    localparam logic [2:0] REG_MAX_HDR  = 3'd0;
    localparam logic [2:0] REG_MAX_BODY = 3'd4;

    localparam int unsigned HDR_W  = 17;
    localparam int unsigned BODY_W = 25;
    localparam logic [3:0]  KEY_LEN = 4'd14;

    localparam logic [HDR_W-1:0]  MAX_HDR_RESET  = 17'd65536;
    localparam logic [BODY_W-1:0] MAX_BODY_RESET = 25'd16777216;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // lower-case header name, one character per position
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/clfd_parse.sv
`timescale 1ns / 1ps

module clfd_parse
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  clfd_pkg::in_item_t              item,
    input  logic [clfd_pkg::HDR_W-1:0]      max_hdr,
    input  logic [clfd_pkg::BODY_W-1:0]     max_body,
    output logic                            res_valid,
    output clfd_pkg::out_item_t             res
);
    import clfd_pkg::*;

    logic              in_body_reg, in_body_next;
    logic [HDR_W-1:0]  hcnt_reg, hcnt_next;
    logic              prev_cr_reg, prev_cr_next;
    logic              crlf_reg, crlf_next;
    logic [2:0]        phase_reg, phase_next;
    logic [3:0]        mpos_reg, mpos_next;
    logic              mism_reg, mism_next;
    logic              is_len_reg, is_len_next;
    logic [63:0]       acc_reg, acc_next;
    logic              vdig_reg, vdig_next;
    logic              vbad_reg, vbad_next;
    logic              seen_reg, seen_next;
    logic [3:0]        pend_reg, pend_next;
    logic [BODY_W-1:0] rem_reg, rem_next;
    logic [3:0]        sticky_reg, sticky_next;

    logic [7:0]  b;
    logic [7:0]  lo;
    logic        ws;
    logic        dig;
    logic [2:0]  ph;
    logic [67:0] acc_x10;
    logic [HDR_W:0] hcnt_inc;
    logic [BODY_W-1:0] rem_dec;

    assign b        = item.data_byte;
    assign lo       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    assign ws       = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
    assign dig      = (b >= "0") && (b <= "9");
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {64'd0, b[3:0] - 4'd0};
    assign hcnt_inc = {1'b0, hcnt_reg} + {{HDR_W{1'b0}}, 1'b1};
    assign rem_dec  = rem_reg - {{(BODY_W-1){1'b0}}, 1'b1};
    assign ph       = (phase_reg == PH_EMPTY_FIRST) ? PH_NAME_LEAD : phase_reg;

    always_comb
    begin
        in_body_next = in_body_reg;
        hcnt_next    = hcnt_reg;
        prev_cr_next = prev_cr_reg;
        crlf_next    = crlf_reg;
        phase_next   = phase_reg;
        mpos_next    = mpos_reg;
        mism_next    = mism_reg;
        is_len_next  = is_len_reg;
        acc_next     = acc_reg;
        vdig_next    = vdig_reg;
        vbad_next    = vbad_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        rem_next     = rem_reg;
        sticky_next  = sticky_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (take) begin
            if (item.op == OP_EOS) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                if (sticky_reg != 4'd0) begin
                    res.error_code = sticky_reg[2:0] - 3'd1;
                end
                else if (in_body_reg || hcnt_reg != '0) begin
                    res.error_code = ERR_PARTIAL;
                    sticky_next    = {1'b0, ERR_PARTIAL} + 4'd1;
                end
                else begin
                    res.kind = KIND_END;
                end
            end
            else if (sticky_reg != 4'd0) begin
                // swallow bytes after an error
            end
            else if (in_body_reg) begin
                rem_next       = rem_dec;
                res_valid      = 1'b1;
                res.kind       = KIND_BODY;
                res.body_byte  = b;
                if (rem_dec == '0) begin
                    in_body_next   = 1'b0;
                    res.frame_last = 1'b1;
                end
            end
            else if (hcnt_inc > {1'b0, max_hdr}) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_HDR_BIG;
                sticky_next    = {1'b0, ERR_HDR_BIG} + 4'd1;
            end
            else if (prev_cr_reg) begin
                if (b != CH_LF) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_DELIM;
                    sticky_next    = {1'b0, ERR_DELIM} + 4'd1;
                end
                else begin
                    hcnt_next    = hcnt_inc[HDR_W-1:0];
                    prev_cr_next = 1'b0;
                    phase_next   = PH_NAME_LEAD;
                    mpos_next    = '0;
                    mism_next    = 1'b0;
                    is_len_next  = 1'b0;
                    acc_next     = '0;
                    vdig_next    = 1'b0;
                    vbad_next    = 1'b0;
                    if (crlf_reg) begin
                        // header end: clear header state, then report
                        hcnt_next = '0;
                        crlf_next = 1'b0;
                        seen_next = 1'b0;
                        pend_next = '0;
                        if (pend_reg != 4'd0) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = pend_reg[2:0] - 3'd1;
                            sticky_next    = pend_reg;
                        end
                        else if (!seen_reg) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_MISSING;
                            sticky_next    = {1'b0, ERR_MISSING} + 4'd1;
                        end
                        else if (rem_reg == '0) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_EMPTY;
                            res.frame_last = 1'b1;
                        end
                        else begin
                            in_body_next = 1'b1;
                        end
                    end
                    else begin
                        crlf_next = 1'b1;
                        if (hcnt_inc[HDR_W-1:0] == HDR_W'(2)) begin
                            phase_next = PH_EMPTY_FIRST;
                        end
                        else if (pend_reg == 4'd0) begin
                            if (phase_reg <= PH_NAME_TRAIL) begin
                                pend_next = {1'b0, ERR_LINE} + 4'd1;
                            end
                            else if (is_len_reg) begin
                                if (seen_reg)
                                    pend_next = {1'b0, ERR_DUP} + 4'd1;
                                else if (vbad_reg || !vdig_reg)
                                    pend_next = {1'b0, ERR_INVALID} + 4'd1;
                                else if (acc_reg > {39'd0, max_body})
                                    pend_next = {1'b0, ERR_BODY_BIG} + 4'd1;
                                else begin
                                    seen_next = 1'b1;
                                    rem_next  = acc_reg[BODY_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            else if (b == CH_LF) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_DELIM;
                sticky_next    = {1'b0, ERR_DELIM} + 4'd1;
            end
            else if (b == CH_CR) begin
                hcnt_next    = hcnt_inc[HDR_W-1:0];
                prev_cr_next = 1'b1;
            end
            else begin
                hcnt_next  = hcnt_inc[HDR_W-1:0];
                crlf_next  = 1'b0;
                phase_next = ph;
                if (phase_reg == PH_EMPTY_FIRST && pend_reg == 4'd0)
                    pend_next = {1'b0, ERR_LINE} + 4'd1;
                unique case (ph)
                    PH_NAME_LEAD:
                    begin
                        if (ws) begin
                        end
                        else if (b == CH_COLON) begin
                            is_len_next = 1'b0;
                            phase_next  = PH_SKIP;
                        end
                        else begin
                            phase_next = PH_NAME;
                            if (mpos_reg < KEY_LEN && lo == key_char(mpos_reg))
                                mpos_next = mpos_reg + 4'd1;
                            else
                                mism_next = 1'b1;
                        end
                    end
                    PH_NAME, PH_NAME_TRAIL:
                    begin
                        if (ws) begin
                            if (ph == PH_NAME) phase_next = PH_NAME_TRAIL;
                        end
                        else if (b == CH_COLON) begin
                            is_len_next = !mism_reg && mpos_reg == KEY_LEN;
                            phase_next  = (!mism_reg && mpos_reg == KEY_LEN)
                                        ? PH_VAL_LEAD : PH_SKIP;
                        end
                        else if (ph == PH_NAME_TRAIL) begin
                            mism_next  = 1'b1;
                            phase_next = PH_NAME;
                        end
                        else if (mpos_reg < KEY_LEN && lo == key_char(mpos_reg)) begin
                            mpos_next = mpos_reg + 4'd1;
                        end
                        else begin
                            mism_next = 1'b1;
                        end
                    end
                    PH_VAL_LEAD, PH_VAL_DIGITS, PH_VAL_TRAIL:
                    begin
                        if (dig && ph != PH_VAL_TRAIL) begin
                            if (acc_x10[67:64] != 4'd0) begin
                                vbad_next  = 1'b1;
                                phase_next = PH_SKIP;
                            end
                            else begin
                                acc_next   = acc_x10[63:0];
                                vdig_next  = 1'b1;
                                phase_next = PH_VAL_DIGITS;
                            end
                        end
                        else if (ws) begin
                            if (ph == PH_VAL_DIGITS) phase_next = PH_VAL_TRAIL;
                        end
                        else begin
                            vbad_next  = 1'b1;
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_body_reg <= 1'b0;
            hcnt_reg    <= '0;
            prev_cr_reg <= 1'b0;
            crlf_reg    <= 1'b0;
            phase_reg   <= PH_NAME_LEAD;
            mpos_reg    <= '0;
            mism_reg    <= 1'b0;
            is_len_reg  <= 1'b0;
            acc_reg     <= '0;
            vdig_reg    <= 1'b0;
            vbad_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            pend_reg    <= '0;
            rem_reg     <= '0;
            sticky_reg  <= '0;
        end
        else begin
            in_body_reg <= in_body_next;
            hcnt_reg    <= hcnt_next;
            prev_cr_reg <= prev_cr_next;
            crlf_reg    <= crlf_next;
            phase_reg   <= phase_next;
            mpos_reg    <= mpos_next;
            mism_reg    <= mism_next;
            is_len_reg  <= is_len_next;
            acc_reg     <= acc_next;
            vdig_reg    <= vdig_next;
            vbad_reg    <= vbad_next;
            seen_reg    <= seen_next;
            pend_reg    <= pend_next;
            rem_reg     <= rem_next;
            sticky_reg  <= sticky_next;
        end
    end

endmodule

FILE: sv/clfd_fifo.sv
`timescale 1ns / 1ps

module clfd_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  clfd_pkg::out_item_t wdata,
    input  logic                rd,
    output clfd_pkg::out_item_t rdata,
    output logic                full,
    output logic                empty
);
    import clfd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    out_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        if (do_rd)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/content_length_frame_decoder_top.sv
`timescale 1ns / 1ps
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------
// input     | push / full            | in_item  (op, data_byte)
// result    | pop / empty            | out_item (kind, body_byte,
//           |                        |           frame_last, error_code)
// config    | psel, penable, pwrite  | paddr, pwdata, prdata
//
// One byte is taken per cycle while full is low, as the parser updates per byte.
// A result is queued the same cycle and can be popped on the next edge.
// rst_n clears all parser state and the result queue; limits return to
// 64 KiB header and 16 MiB body. full rises only when the result queue
// holds FIFO_DEPTH transactions the consumer has not popped.

module content_length_frame_decoder_top
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  clfd_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output clfd_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import clfd_pkg::*;

    logic [HDR_W-1:0]  max_hdr_reg;
    logic [BODY_W-1:0] max_body_reg;
    logic              take;
    logic              res_valid;
    out_item_t         res;

    // Register writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign take   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_hdr_reg  <= MAX_HDR_RESET;
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (psel && penable && pwrite) begin
            // decode on the register-select bit only
            if (paddr[2] == REG_MAX_BODY[2])
                max_body_reg <= pwdata[BODY_W-1:0];
            else
                max_hdr_reg  <= pwdata[HDR_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_BODY[2])
            prdata = {{(32-BODY_W){1'b0}}, max_body_reg};
        else
            prdata = {{(32-HDR_W){1'b0}}, max_hdr_reg};
    end

    // Front: classify every byte and update the framing state.
    clfd_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_item),
        .max_hdr   (max_hdr_reg),
        .max_body  (max_body_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Back: hold finished transactions until the consumer pops them.
    clfd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .rd    (pop),
        .rdata (out_item),
        .full  (full),
        .empty (empty)
    );

endmodule

FILE: sv/clfd_checker.sv
`timescale 1ns / 1ps

module clfd_assert
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                empty,
    input  logic                pop,
    input  clfd_pkg::out_item_t out_item,
    input  logic                pready
);
    import clfd_pkg::*;

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty at once");

    a_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without an input transaction");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.frame_last) |->
        (out_item.kind == KIND_BODY || out_item.kind == KIND_EMPTY))
        else $error("frame_last on wrong kind");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.kind != KIND_ERROR) |-> (out_item.error_code == 3'd0))
        else $error("error code on non-error result");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind content_length_frame_decoder_top clfd_assert u_clfd_assert
(
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .pready   (pready)
);

FILE: sim/clfd_checker.sv
`timescale 1ns / 1ps

module clfd_checker
    import clfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_item_t    in_item,
    input  logic        empty,
    input  logic        pop,
    input  out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          awaited
);

    localparam string KEY_NAME = "content-length";
    localparam logic [1:0] VF_DIGIT = 2'b01;
    localparam logic [1:0] VF_BAD   = 2'b10;

    out_item_t awaited_q[$];
    int        mismatches;

    logic [HDR_W-1:0]  hdr_limit;
    logic [BODY_W-1:0] body_limit;

    logic              in_body;
    logic [HDR_W-1:0]  hdr_cnt;
    logic              prev_cr;
    logic              crlf_seen;
    logic [2:0]        phase;
    logic [3:0]        match_pos;
    logic              name_bad;
    logic              is_len_line;
    logic [63:0]       accum;
    logic [1:0]        vflags;
    logic              seen_len;
    logic [3:0]        pending;
    logic [BODY_W-1:0] body_left;
    logic [3:0]        sticky;

    assign fail_count = mismatches;
    assign awaited    = awaited_q.size();

    function automatic bit is_ws(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C;
    endfunction

    function void expect_out(logic [1:0] k, logic [7:0] b, logic last, logic [2:0] code);
        out_item_t o;
        o.kind       = k;
        o.body_byte  = b;
        o.frame_last = last;
        o.error_code = code;
        awaited_q.push_back(o);
    endfunction

    function void raise_error(logic [2:0] code);
        sticky = {1'b0, code} + 4'd1;
        expect_out(KIND_ERROR, 8'h00, 1'b0, code);
    endfunction

    function void hold_line_error(logic [2:0] code);
        if (pending == 4'd0)
            pending = {1'b0, code} + 4'd1;
    endfunction

    function void clear_line();
        phase       = PH_NAME_LEAD;
        match_pos   = 4'd0;
        name_bad    = 1'b0;
        is_len_line = 1'b0;
        accum       = 64'd0;
        vflags      = 2'b00;
    endfunction

    function void clear_header();
        clear_line();
        hdr_cnt   = '0;
        prev_cr   = 1'b0;
        crlf_seen = 1'b0;
        seen_len  = 1'b0;
        pending   = 4'd0;
    endfunction

    function void match_name(logic [7:0] b);
        logic [7:0] lo;
        lo = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (match_pos < 4'd14 && lo == KEY_NAME[match_pos])
            match_pos = match_pos + 4'd1;
        else
            name_bad = 1'b1;
    endfunction

    function void close_name();
        is_len_line = !name_bad && match_pos == 4'd14;
        phase       = is_len_line ? PH_VAL_LEAD : PH_SKIP;
    endfunction

    function void take_digit(logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - 8'h30};
        if (accum > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
            vflags = vflags | VF_BAD;
            phase  = PH_SKIP;
        end
        else begin
            accum  = accum * 64'd10 + d;
            vflags = vflags | VF_DIGIT;
            phase  = PH_VAL_DIGITS;
        end
    endfunction

    function void header_char(logic [7:0] b);
        bit ws;
        bit dig;
        ws  = is_ws(b);
        dig = b >= "0" && b <= "9";
        if (phase == PH_EMPTY_FIRST) begin
            hold_line_error(ERR_LINE);
            phase = PH_NAME_LEAD;
        end
        case (phase)
            PH_NAME_LEAD:
                if (!ws) begin
                    if (b == CH_COLON) begin
                        is_len_line = 1'b0;
                        phase       = PH_SKIP;
                    end
                    else begin
                        phase = PH_NAME;
                        match_name(b);
                    end
                end
            PH_NAME:
                if (ws) phase = PH_NAME_TRAIL;
                else if (b == CH_COLON) close_name();
                else match_name(b);
            PH_NAME_TRAIL:
                if (!ws) begin
                    if (b == CH_COLON) close_name();
                    else begin
                        name_bad = 1'b1;
                        phase    = PH_NAME;
                    end
                end
            PH_VAL_LEAD:
                if (!ws) begin
                    if (dig) take_digit(b);
                    else begin
                        vflags = vflags | VF_BAD;
                        phase  = PH_SKIP;
                    end
                end
            PH_VAL_DIGITS:
                if (dig) take_digit(b);
                else if (ws) phase = PH_VAL_TRAIL;
                else begin
                    vflags = vflags | VF_BAD;
                    phase  = PH_SKIP;
                end
            PH_VAL_TRAIL:
                if (!ws) begin
                    vflags = vflags | VF_BAD;
                    phase  = PH_SKIP;
                end
            default: ;
        endcase
    endfunction

    function void close_line();
        if (hdr_cnt == 17'd2) begin
            clear_line();
            phase = PH_EMPTY_FIRST;
        end
        else begin
            if (pending == 4'd0) begin
                if (phase <= PH_NAME_TRAIL)
                    hold_line_error(ERR_LINE);
                else if (is_len_line) begin
                    if (seen_len)
                        hold_line_error(ERR_DUP);
                    else if ((vflags & VF_BAD) != 0 || (vflags & VF_DIGIT) == 0)
                        hold_line_error(ERR_INVALID);
                    else if (accum > {39'd0, body_limit})
                        hold_line_error(ERR_BODY_BIG);
                    else begin
                        seen_len  = 1'b1;
                        body_left = accum[BODY_W-1:0];
                    end
                end
            end
            clear_line();
        end
    endfunction

    // advance the decoder copy by one accepted transaction
    function void decode_item(in_item_t it);
        logic [7:0] b;
        logic [3:0] held;
        logic       had_len;
        b = it.data_byte;
        if (it.op == OP_EOS) begin
            if (sticky != 4'd0)
                expect_out(KIND_ERROR, 8'h00, 1'b0, sticky[2:0] - 3'd1);
            else if (in_body || hdr_cnt != '0)
                raise_error(ERR_PARTIAL);
            else
                expect_out(KIND_END, 8'h00, 1'b0, 3'd0);
        end
        else if (sticky != 4'd0) begin
        end
        else if (in_body) begin
            body_left = body_left - 1'b1;
            if (body_left == '0) begin
                in_body = 1'b0;
                expect_out(KIND_BODY, b, 1'b1, 3'd0);
            end
            else
                expect_out(KIND_BODY, b, 1'b0, 3'd0);
        end
        else if ({15'd0, hdr_cnt} + 32'd1 > {15'd0, hdr_limit})
            raise_error(ERR_HDR_BIG);
        else if (prev_cr) begin
            if (b != CH_LF)
                raise_error(ERR_DELIM);
            else begin
                hdr_cnt = hdr_cnt + 1'b1;
                prev_cr = 1'b0;
                if (crlf_seen) begin
                    held    = pending;
                    had_len = seen_len;
                    clear_header();
                    if (held != 4'd0) raise_error(held[2:0] - 3'd1);
                    else if (!had_len) raise_error(ERR_MISSING);
                    else if (body_left == '0) expect_out(KIND_EMPTY, 8'h00, 1'b1, 3'd0);
                    else in_body = 1'b1;
                end
                else begin
                    close_line();
                    crlf_seen = 1'b1;
                end
            end
        end
        else if (b == CH_LF)
            raise_error(ERR_DELIM);
        else begin
            hdr_cnt = hdr_cnt + 1'b1;
            if (b == CH_CR)
                prev_cr = 1'b1;
            else begin
                crlf_seen = 1'b0;
                header_char(b);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            awaited_q.delete();
            mismatches = 0;
            hdr_limit  = MAX_HDR_RESET;
            body_limit = MAX_BODY_RESET;
            in_body    = 1'b0;
            body_left  = '0;
            sticky     = 4'd0;
            clear_header();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_MAX_HDR)  hdr_limit  = pwdata[HDR_W-1:0];
                if (paddr == REG_MAX_BODY) body_limit = pwdata[BODY_W-1:0];
            end
            if (pop && !empty) begin
                if (awaited_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %p", $time,
                             out_item);
                end
                else begin
                    want = awaited_q.pop_front();
                    if (want.kind !== out_item.kind || want.body_byte !== out_item.body_byte
                        || want.frame_last !== out_item.frame_last
                        || want.error_code !== out_item.error_code) begin
                        mismatches++;
                        $display("%0t: result mismatch, expected %p, actual %p", $time,
                                 want, out_item);
                    end
                end
            end
            if (push && !full)
                decode_item(in_item);
        end
    end

endmodule

FILE: sim/tb_content_length_frame_decoder_top.sv
`timescale 1ns / 1ps

module tb_content_length_frame_decoder_top;
    import clfd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    in_item;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int awaited;

    // idle rates in percent, changed between phases
    int send_idle;
    int recv_idle;
    // receiver hold-off length, counted down by the receiver process
    int hold_left;
    // set at the edge where the last driven transaction went in
    logic took;
    int   quiet_cycles;

    logic [8:0] stream_q[$];
    int unsigned body_cap;

    localparam int WATCHDOG_LIMIT = 4000;

    content_length_frame_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    clfd_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        took <= push && !full;
    end

    // Receiver: pop at the chosen rate, or hold off entirely while a
    // long stall is in progress so that the result queue backs up.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (hold_left > 0) begin
            pop = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            pop = $urandom_range(0, 99) >= recv_idle;
    end

    // Watchdog: count cycles in which no transaction moves on any channel.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one transaction and hold it until it is taken.
    // Called at a falling edge and returns at one.
    task automatic send_one(logic op, logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle) begin
            push = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        push            = 1'b1;
        in_item.op      = op;
        in_item.data_byte = b;
        @(negedge clk);
        while (!took) @(negedge clk);
    endtask

    task automatic drain_stream();
        while (stream_q.size() > 0) begin
            logic [8:0] v;
            v = stream_q.pop_front();
            send_one(v[8], v[7:0]);
        end
    endtask

    // Drop push and wait until every expected result has been popped,
    // then let the parser settle before touching the registers.
    task automatic wait_quiet();
        push = 1'b0;
        while (awaited != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function void add_byte(logic [7:0] b);
        stream_q.push_back({OP_BYTE, b});
    endfunction

    function void add_eos();
        stream_q.push_back({OP_EOS, 8'h00});
    endfunction

    function void add_text(string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function void add_ws(int most);
        repeat ($urandom_range(0, most)) add_byte(pick_ws());
    endfunction

    function void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // Filler header line; the leading x keeps it from ever matching the length name.
    function void add_filler_line();
        add_ws(1);
        add_byte("x");
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
        add_ws(1);
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        add_crlf();
    endfunction

    // Length line with random case, padding and leading zeros.
    function void add_length_line(string value);
        string name;
        name = "content-length";
        add_ws(1);
        foreach (name[i]) begin
            if (name[i] != "-" && $urandom_range(0, 1))
                add_byte(name[i] - 8'd32);
            else
                add_byte(name[i]);
        end
        add_ws(1);
        add_byte(CH_COLON);
        add_ws(2);
        repeat ($urandom_range(0, 2)) add_byte("0");
        add_text(value);
        add_ws(1);
        add_crlf();
    endfunction

    function void add_body(int unsigned n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function void add_frame();
        int unsigned n;
        n = $urandom_range(0, (body_cap < 40) ? body_cap : 40);
        if ($urandom_range(0, 5) == 0) n = 0;
        repeat ($urandom_range(0, 2)) add_filler_line();
        add_length_line($sformatf("%0d", n));
        repeat ($urandom_range(0, 2)) add_filler_line();
        add_crlf();
        add_body(n);
    endfunction

    // Send well-formed frames until the item budget is spent, with the odd
    // clean end of stream between frames.
    task automatic run_frames(int unsigned items);
        int unsigned sent;
        sent = 0;
        while (sent < items) begin
            add_frame();
            if ($urandom_range(0, 4) == 0) add_eos();
            sent += stream_q.size();
            drain_stream();
        end
    endtask

    // The first error is sticky for the rest of the run, so exactly one
    // error case is picked and played out at the very end.
    task automatic run_error_case();
        case ($urandom_range(0, 12))
            0: begin
                cfg_write(REG_MAX_HDR, 32'd4);
                add_frame();
            end
            1: add_text("content-length: 3\n");
            2: add_text("content-length: 3\rx");
            3: begin
                add_text("no colon here");
                add_crlf();
                add_length_line("1");
                add_crlf();
            end
            4: begin
                add_length_line("1");
                add_length_line("2");
                add_crlf();
            end
            5: begin
                add_length_line("1x");
                add_crlf();
            end
            6: begin
                add_length_line("18446744073709551616");
                add_crlf();
            end
            7: begin
                add_length_line("18446744073709551615");
                add_crlf();
            end
            8: begin
                add_length_line($sformatf("%0d", body_cap + 1));
                add_crlf();
            end
            9: begin
                add_filler_line();
                add_crlf();
            end
            10: begin
                add_crlf();
                add_crlf();
            end
            11: begin
                add_crlf();
                add_length_line("0");
                add_crlf();
            end
            default: add_text("content-len");
        endcase
        repeat ($urandom_range(2, 6)) add_byte(8'($urandom_range(0, 255)));
        add_eos();
        add_byte(8'hA5);
        add_eos();
        drain_stream();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        pop       = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        hold_left = 0;
        send_idle = 0;
        recv_idle = 0;
        body_cap  = 16777216;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: clean end on an idle stream, an empty frame, a frame
        // whose body carries the byte extremes, then another clean end.
        add_eos();
        add_text("Content-Length:0");
        add_crlf();
        add_crlf();
        add_text("content-length: 2");
        add_crlf();
        add_crlf();
        add_byte(8'hFF);
        add_byte(8'h00);
        add_eos();
        drain_stream();
        wait_quiet();

        // Phase one: limits at their reset defaults, receiver mostly stalled.
        send_idle = 27;
        recv_idle = 67;
        cfg_write(REG_MAX_HDR, 32'd65536);
        cfg_write(REG_MAX_BODY, 32'd16777216);
        run_frames(300);

        // Hold the receiver off while frames keep coming so full rises.
        push = 1'b0;
        @(posedge clk);
        hold_left = 300;
        send_idle = 0;
        @(negedge clk);
        run_frames(120);
        wait_quiet();

        // Phase two: no body allowed, tight header, roles swapped.
        send_idle = 67;
        recv_idle = 27;
        body_cap  = 0;
        cfg_write(REG_MAX_HDR, 32'd200);
        cfg_write(REG_MAX_BODY, 32'd0);
        run_frames(250);
        wait_quiet();

        // Phase three: mid-size limits, no idling on either side.
        send_idle = 0;
        recv_idle = 0;
        body_cap  = 25;
        cfg_write(REG_MAX_HDR, 32'd300);
        cfg_write(REG_MAX_BODY, 32'd25);
        run_frames(450);
        wait_quiet();

        send_idle = 27;
        recv_idle = 27;
        run_error_case();
        wait_quiet();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
